[hw/rtl/lci_pkg.sv]
// Shared widths, types and class codes for the line/circle intersection pipeline.
// No dependencies.
package lci_pkg;

   localparam int CW        = 16;          // input coordinate width
   localparam int DFW       = CW + 1;      // point difference width
   localparam int DW        = 2 * DFW + 1; // cross product width
   localparam int R2W       = 2 * DFW;     // squared length width
   localparam int RRW       = 2 * CW;      // radius squared width
   localparam int EW        = 32;          // tolerance width
   localparam int MW        = 66;          // discriminant magnitude sent to root
   localparam int DIFW      = 69;          // signed discriminant width
   localparam int RTW       = 34;          // root width
   localparam int SQ_STAGES = RTW;
   localparam int NW        = 54;          // signed numerator width
   localparam int QW        = 20;          // quotient magnitude bits
   localparam int DIV_STAGES = QW + 2;
   localparam int OW        = 24;          // output coordinate width
   localparam int REQ_W     = 7 * CW;
   localparam int RSP_W     = 104;

   typedef enum logic [1:0] {
      KIND_MISS,
      KIND_TANGENT,
      KIND_SECANT,
      KIND_DEGEN
   } kind_type;

   typedef struct packed {
      logic signed [DW-1:0]  d;
      logic signed [DFW-1:0] dx;
      logic signed [DFW-1:0] dy;
      logic [R2W-1:0]        dr2;
      logic signed [CW-1:0]  cx;
      logic signed [CW-1:0]  cy;
      kind_type              kind;
   } geo_type;

endpackage

[hw/rtl/line_circle_intersection.sv]
// Top level: line through two points against a circle, pipelined one request per cycle.
// Depends on lci_pkg, lci_front, lci_sqrt, lci_div.
//
//   channel  | direction | fields
//   req_*    | in        | line points, circle center and radius
//   rsp_*    | out       | hit count, degenerate flag, two points, saturated flag
//   csr_*    | in        | tangent tolerance
//
// Accepts one request per cycle unless stalled; the pipeline is 8 front stages, 35 root
// stages, 2 numerator stages, 22 divider stages and 1 output stage, set by the
// one-bit-per-stage square root and dividers. The whole pipeline advances
// when the output register is empty or taken, so a stall holds every stage.
// Synchronous reset clears valid bits and sets the tolerance to 1.
module line_circle_intersection import lci_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // first_x, first_y, second_x, second_y, center_x, center_y, radius
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // hit_count[1:0], degenerate, hit1_x, hit1_y, hit2_x, hit2_y, saturated, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [EW-1:0]    csr_wdata
);

   logic          adv;
   logic [EW-1:0] eps_ff;
   logic          out_v_ff;

   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EW'(1);
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   logic          f_valid;
   logic [MW-1:0] f_mag;
   geo_type       f_geo;

   lci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid && req_tready),
      .in_data   (req_tdata),
      .eps       (eps_ff),
      .out_valid (f_valid),
      .out_mag   (f_mag),
      .out_geo   (f_geo)
   );

   logic           s_valid;
   logic [RTW-1:0] s_root;
   geo_type        s_geo;

   lci_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_mag    (f_mag),
      .in_geo    (f_geo),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_geo   (s_geo)
   );

   // numerator products
   logic signed [51:0] ddy_ff, ddx_ff, dxr_ff;
   logic [50:0]        adyr_ff;
   logic signed [DFW-1:0] ady;
   logic signed [34:0]    root_s;
   geo_type            a_geo_ff, b_geo_ff;
   logic               a_v_ff, b_v_ff;

   assign ady    = s_geo.dy[DFW-1] ? -s_geo.dy : s_geo.dy;
   assign root_s = $signed({1'b0, s_root});

   always_ff @(posedge clock) begin
      if (adv) begin
         ddy_ff   <= 52'(s_geo.d * s_geo.dy);
         ddx_ff   <= 52'(s_geo.d * s_geo.dx);
         dxr_ff   <= 52'(s_geo.dx * root_s);
         adyr_ff  <= 51'(ady[DFW-2:0] * s_root);
         a_geo_ff <= s_geo;
      end
   end

   // numerators
   logic signed [NW-1:0] sdxr, ddy_w, ddx_w, adyr_w;
   logic signed [NW-1:0] n1_ff, n2_ff, n3_ff, n4_ff;

   assign ddy_w  = NW'(ddy_ff);
   assign ddx_w  = NW'(ddx_ff);
   assign adyr_w = $signed({3'b0, adyr_ff});
   assign sdxr   = a_geo_ff.dy[DFW-1] ? -NW'(dxr_ff) : NW'(dxr_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff    <= ddy_w + sdxr;
         n2_ff    <= adyr_w - ddx_w;
         n3_ff    <= ddy_w - sdxr;
         n4_ff    <= -ddx_w - adyr_w;
         b_geo_ff <= a_geo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= s_valid;
         b_v_ff <= a_v_ff;
      end
   end

   logic signed [QW:0] q1, q2, q3, q4;
   logic               d_valid;
   logic [2:0]         d_unused;

   lci_div u_div1 (.clock(clock), .reset(reset), .adv(adv), .in_valid(b_v_ff),
      .in_num(n1_ff), .in_den(b_geo_ff.dr2), .out_valid(d_valid), .out_quo(q1));
   lci_div u_div2 (.clock(clock), .reset(reset), .adv(adv), .in_valid(b_v_ff),
      .in_num(n2_ff), .in_den(b_geo_ff.dr2), .out_valid(d_unused[0]), .out_quo(q2));
   lci_div u_div3 (.clock(clock), .reset(reset), .adv(adv), .in_valid(b_v_ff),
      .in_num(n3_ff), .in_den(b_geo_ff.dr2), .out_valid(d_unused[1]), .out_quo(q3));
   lci_div u_div4 (.clock(clock), .reset(reset), .adv(adv), .in_valid(b_v_ff),
      .in_num(n4_ff), .in_den(b_geo_ff.dr2), .out_valid(d_unused[2]), .out_quo(q4));

   // center and class travel beside the dividers
   geo_type side_ff [0:DIV_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= b_geo_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   geo_type side;
   assign side = side_ff[DIV_STAGES-1];

   function automatic logic [OW:0] clip_coord(input logic signed [QW:0] q,
                                              input logic signed [CW-1:0] c);
      logic signed [OW:0] v;
      begin
         v = (OW+1)'(q) + (OW+1)'(c);
         if (v > $signed((OW+1)'((1 << (OW-1)) - 1))) begin
            clip_coord = {1'b1, 1'b0, {(OW-1){1'b1}}};
         end else if (v < -$signed((OW+1)'(1 << (OW-1)))) begin
            clip_coord = {1'b1, 1'b1, {(OW-1){1'b0}}};
         end else begin
            clip_coord = {1'b0, v[OW-1:0]};
         end
      end
   endfunction

   logic [OW:0] c1, c2, c3, c4;
   logic        hit, sat;
   logic [1:0]  cnt;

   assign c1  = clip_coord(q1, side.cx);
   assign c2  = clip_coord(q2, side.cy);
   assign c3  = clip_coord(q3, side.cx);
   assign c4  = clip_coord(q4, side.cy);
   assign hit = (side.kind == KIND_TANGENT) || (side.kind == KIND_SECANT);
   assign sat = hit && (c1[OW] || c2[OW] || c3[OW] || c4[OW]);
   assign cnt = (side.kind == KIND_SECANT) ? 2'd2 : (side.kind == KIND_TANGENT) ? 2'd1 : 2'd0;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata <= {4'b0, sat,
                       hit ? c4[OW-1:0] : '0,
                       hit ? c3[OW-1:0] : '0,
                       hit ? c2[OW-1:0] : '0,
                       hit ? c1[OW-1:0] : '0,
                       side.kind == KIND_DEGEN,
                       cnt};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= d_valid;
      end
   end

endmodule

[hw/rtl/lci_front.sv]
// Front stages: differences, cross product, squared length, discriminant, class.
// Depends on lci_pkg.
module lci_front import lci_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [REQ_W-1:0] in_data,
   input  logic [EW-1:0]    eps,
   output logic             out_valid,
   output logic [MW-1:0]    out_mag,
   output geo_type          out_geo
);

   logic [7:0] v_ff;

   // stage 1
   logic signed [CW-1:0]  fx, fy, sx, sy, cx, cy;
   logic signed [DFW-1:0] ax_ff, ay_ff, bx_ff, by_ff, dx1_ff, dy1_ff;
   logic signed [CW-1:0]  cx1_ff, cy1_ff;
   logic [CW-1:0]         r1_ff;

   assign fx = $signed(in_data[15:0]);
   assign fy = $signed(in_data[31:16]);
   assign sx = $signed(in_data[47:32]);
   assign sy = $signed(in_data[63:48]);
   assign cx = $signed(in_data[79:64]);
   assign cy = $signed(in_data[95:80]);

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff  <= DFW'(fx) - DFW'(cx);
         ay_ff  <= DFW'(fy) - DFW'(cy);
         bx_ff  <= DFW'(sx) - DFW'(cx);
         by_ff  <= DFW'(sy) - DFW'(cy);
         dx1_ff <= DFW'(sx) - DFW'(fx);
         dy1_ff <= DFW'(sy) - DFW'(fy);
         cx1_ff <= cx;
         cy1_ff <= cy;
         r1_ff  <= in_data[111:96];
      end
   end

   // stage 2: products
   logic signed [R2W-1:0] pab_ff, pba_ff, pxx_ff, pyy_ff;
   logic [RRW-1:0]        rr2_ff;
   logic signed [DFW-1:0] dx2_ff, dy2_ff;
   logic signed [CW-1:0]  cx2_ff, cy2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pab_ff <= ax_ff * by_ff;
         pba_ff <= ay_ff * bx_ff;
         pxx_ff <= dx1_ff * dx1_ff;
         pyy_ff <= dy1_ff * dy1_ff;
         rr2_ff <= r1_ff * r1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         cx2_ff <= cx1_ff;
         cy2_ff <= cy1_ff;
      end
   end

   // stage 3: cross product and squared length
   geo_type        g3_ff, g4_ff, g5_ff, g6_ff, g7_ff;
   logic [RRW-1:0] rr3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         g3_ff.d    <= DW'(pab_ff) - DW'(pba_ff);
         g3_ff.dr2  <= {1'b0, pxx_ff[R2W-2:0]} + {1'b0, pyy_ff[R2W-2:0]};
         g3_ff.dx   <= dx2_ff;
         g3_ff.dy   <= dy2_ff;
         g3_ff.cx   <= cx2_ff;
         g3_ff.cy   <= cy2_ff;
         g3_ff.kind <= KIND_MISS;
         rr3_ff     <= rr2_ff;
      end
   end

   // stage 4: |D| and r^2*dr2 partial products
   logic signed [DW-1:0] dneg;
   logic [33:0]          dmag4_ff;
   logic [32:0]          pp0_ff, pp1_ff, pp2_ff, pp3_ff;

   assign dneg = -g3_ff.d;

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag4_ff <= g3_ff.d[DW-1] ? dneg[33:0] : g3_ff.d[33:0];
         pp0_ff   <= rr3_ff[15:0]  * g3_ff.dr2[16:0];
         pp1_ff   <= rr3_ff[15:0]  * g3_ff.dr2[33:17];
         pp2_ff   <= rr3_ff[31:16] * g3_ff.dr2[16:0];
         pp3_ff   <= rr3_ff[31:16] * g3_ff.dr2[33:17];
         g4_ff    <= g3_ff;
      end
   end

   // stage 5: D^2 partial products, sum of r^2*dr2
   logic [33:0] qq0_ff, qq1_ff, qq2_ff;
   logic [65:0] p5_ff, p6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         qq0_ff <= dmag4_ff[16:0]  * dmag4_ff[16:0];
         qq1_ff <= dmag4_ff[16:0]  * dmag4_ff[33:17];
         qq2_ff <= dmag4_ff[33:17] * dmag4_ff[33:17];
         p5_ff  <= 66'(pp0_ff) + (66'(pp1_ff) << 17) + (66'(pp2_ff) << 16)
                 + (66'(pp3_ff) << 33);
         g5_ff  <= g4_ff;
      end
   end

   // stage 6: sum of D^2
   logic [67:0] q6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         q6_ff <= 68'(qq0_ff) + (68'(qq1_ff) << 18) + (68'(qq2_ff) << 34);
         p6_ff <= p5_ff;
         g6_ff <= g5_ff;
      end
   end

   // stage 7: discriminant magnitude and sign
   logic [DIFW-1:0] diff;
   logic [DIFW-1:0] diffn;
   logic [67:0]     mag7_ff;
   logic            neg7_ff;

   assign diff  = {3'b0, p6_ff} - {1'b0, q6_ff};
   assign diffn = -diff;

   always_ff @(posedge clock) begin
      if (adv) begin
         neg7_ff <= diff[DIFW-1];
         mag7_ff <= diff[DIFW-1] ? diffn[67:0] : diff[67:0];
         g7_ff   <= g6_ff;
      end
   end

   // stage 8: classify
   logic     miss, tangent;
   kind_type kind8;
   geo_type  geo8;

   assign miss    = neg7_ff && ({mag7_ff, 1'b0} > 69'(eps));
   assign tangent = mag7_ff <= 68'(eps);

   always_comb begin
      if (g7_ff.dr2 == '0)  kind8 = KIND_DEGEN;
      else if (miss)        kind8 = KIND_MISS;
      else if (tangent)     kind8 = KIND_TANGENT;
      else                  kind8 = KIND_SECANT;
   end

   always_comb begin
      geo8      = g7_ff;
      geo8.kind = kind8;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_geo <= geo8;
         out_mag <= (kind8 == KIND_SECANT) ? mag7_ff[MW-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[6:0], in_valid};
      end
   end

   assign out_valid = v_ff[7];

endmodule

[hw/rtl/lci_sqrt.sv]
// Pipelined integer square root, one result bit per stage, geometry carried alongside.
// Depends on lci_pkg.
module lci_sqrt import lci_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  logic [MW-1:0]  in_mag,
   input  geo_type        in_geo,
   output logic           out_valid,
   output logic [RTW-1:0] out_root,
   output geo_type        out_geo
);

   localparam int TW = MW + 2;

   logic [MW-1:0]  rem_ff [0:SQ_STAGES];
   logic [RTW-1:0] res_ff [0:SQ_STAGES];
   geo_type        geo_ff [0:SQ_STAGES];
   logic [SQ_STAGES:0] v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= in_mag;
         res_ff[0] <= '0;
         geo_ff[0] <= in_geo;
      end
   end

   for (genvar i = 0; i < SQ_STAGES; i++) begin : g_bit
      localparam int B = SQ_STAGES - 1 - i;
      logic [TW-1:0] trial;
      logic [TW-1:0] rem_x;
      logic          take;

      assign rem_x = {2'b0, rem_ff[i]};
      assign trial = (TW'(res_ff[i]) << (B + 1)) + (TW'(1) << (2 * B));
      assign take  = rem_x >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i+1] <= take ? MW'(rem_x - trial) : rem_ff[i];
            res_ff[i+1] <= take ? (res_ff[i] | (RTW'(1) << B)) : res_ff[i];
            geo_ff[i+1] <= geo_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[SQ_STAGES-1:0], in_valid};
      end
   end

   assign out_valid = v_ff[SQ_STAGES];
   assign out_root  = res_ff[SQ_STAGES];
   assign out_geo   = geo_ff[SQ_STAGES];

endmodule

[hw/rtl/lci_div.sv]
// Pipelined floored division of a signed numerator by an unsigned denominator.
// Depends on lci_pkg.
module lci_div import lci_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [NW-1:0] in_num,
   input  logic [R2W-1:0]      in_den,
   output logic                out_valid,
   output logic signed [QW:0]  out_quo
);

   logic [NW-1:0]  rem_ff [0:QW];
   logic [QW-1:0]  qm_ff  [0:QW];
   logic [R2W-1:0] den_ff [0:QW];
   logic [QW:0]    neg_ff;
   logic [QW+1:0]  v_ff;
   logic [NW-1:0]  nneg;

   assign nneg = -in_num;

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= in_num[NW-1] ? nneg : in_num;
         qm_ff[0]  <= '0;
         den_ff[0] <= in_den;
         neg_ff[0] <= in_num[NW-1];
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int B = QW - 1 - j;
      logic [NW-1:0] trial;
      logic          take;

      assign trial = NW'(den_ff[j]) << B;
      assign take  = rem_ff[j] >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= take ? rem_ff[j] - trial : rem_ff[j];
            qm_ff[j+1]  <= take ? (qm_ff[j] | (QW'(1) << B)) : qm_ff[j];
            den_ff[j+1] <= den_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
      end
   end

   logic signed [QW:0] qpos;
   assign qpos = $signed({1'b0, qm_ff[QW]});

   always_ff @(posedge clock) begin
      if (adv) begin
         if (neg_ff[QW]) begin
            out_quo <= -qpos - ((rem_ff[QW] != '0) ? (QW+1)'(1) : (QW+1)'(0));
         end else begin
            out_quo <= qpos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[QW:0], in_valid};
      end
   end

   assign out_valid = v_ff[QW+1];

endmodule
